### rtl/core/sfp_pkg.sv
package sfp_pkg;

    // Default ring depth in slots; one slot always stays empty
    localparam int DEPTH_DEF = 64;

    localparam int BYTE_W = 8;
    localparam int RXC_W  = 6;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_SEND     = 2'd0,
        REQ_READ     = 2'd1,
        REQ_LINE_RX  = 2'd2,
        REQ_LINE_RDY = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type         req_type;
        logic [BYTE_W-1:0] byte_in;
    } t_in;

    typedef struct packed {
        logic              line_valid;
        logic [BYTE_W-1:0] line_byte;
        logic [BYTE_W-1:0] read_byte;
        logic              accepted;
        logic [RXC_W-1:0]  rx_count;
        logic              tx_busy;
    } t_out;

    // Result of a request whose ring read is still in flight
    typedef struct packed {
        logic              line_valid;
        logic [BYTE_W-1:0] line_byte;
        logic              take_tx;
        logic              take_rx;
        logic              accepted;
        logic [RXC_W-1:0]  rx_count;
        logic              tx_busy;
    } t_pend;

    // Ring memory strobes
    typedef struct packed {
        logic tx_we;
        logic tx_re;
        logic rx_we;
        logic rx_re;
    } t_mem_ctl;

endpackage

### rtl/core/sfp_ram.sv
module sfp_ram #(
    parameter int WIDTH = sfp_pkg::BYTE_W,
    parameter int DEPTH = sfp_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/sfp_ctrl.sv
module sfp_ctrl #(
    parameter int DEPTH = sfp_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  sfp_pkg::t_in             i_req,
    output sfp_pkg::t_mem_ctl        o_mem,
    output logic [$clog2(DEPTH)-1:0] o_tx_waddr,
    output logic [$clog2(DEPTH)-1:0] o_tx_raddr,
    output logic [$clog2(DEPTH)-1:0] o_rx_waddr,
    output logic [$clog2(DEPTH)-1:0] o_rx_raddr,
    output sfp_pkg::t_pend           o_pend
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] r_tx_head, r_tx_tail, r_rx_head, r_rx_tail;
    logic [PTR_W-1:0] n_tx_head, n_tx_tail, n_rx_head, n_rx_tail;
    logic             r_sending, n_sending;

    sfp_pkg::t_mem_ctl s_mem;
    sfp_pkg::t_pend    s_pend;
    logic [CNT_W-1:0]  s_rx_cnt;
    logic [sfp_pkg::RXC_W+CNT_W-1:0] s_rx_cnt_ext;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == LAST_C) ? '0 : p + 1'b1;
        return q;
    endfunction

    // Decode the request against the current pointers
    always_comb begin
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_sending = r_sending;
        s_mem     = '0;
        s_pend    = '0;
        unique case (i_req.req_type)
            sfp_pkg::REQ_SEND: begin
                if (!r_sending) begin
                    s_pend.line_valid = 1'b1;
                    s_pend.line_byte  = i_req.byte_in;
                    s_pend.accepted   = 1'b1;
                    n_sending         = 1'b1;
                end else if (f_next(r_tx_head) != r_tx_tail) begin
                    s_mem.tx_we     = 1'b1;
                    s_pend.accepted = 1'b1;
                    n_tx_head       = f_next(r_tx_head);
                end
            end
            sfp_pkg::REQ_READ: begin
                if (r_rx_head != r_rx_tail) begin
                    s_mem.rx_re     = 1'b1;
                    s_pend.take_rx  = 1'b1;
                    s_pend.accepted = 1'b1;
                    n_rx_tail       = f_next(r_rx_tail);
                end
            end
            sfp_pkg::REQ_LINE_RX: begin
                if (f_next(r_rx_head) != r_rx_tail) begin
                    s_mem.rx_we     = 1'b1;
                    s_pend.accepted = 1'b1;
                    n_rx_head       = f_next(r_rx_head);
                end
            end
            sfp_pkg::REQ_LINE_RDY: begin
                if (r_sending) begin
                    if (r_tx_head == r_tx_tail) begin
                        n_sending = 1'b0;
                    end else begin
                        s_mem.tx_re       = 1'b1;
                        s_pend.take_tx    = 1'b1;
                        s_pend.line_valid = 1'b1;
                        s_pend.accepted   = 1'b1;
                        n_tx_tail         = f_next(r_tx_tail);
                    end
                end
            end
        endcase

        // Receive fill level after this request
        if (n_rx_head >= n_rx_tail) begin
            s_rx_cnt = CNT_W'(n_rx_head) - CNT_W'(n_rx_tail);
        end else begin
            s_rx_cnt = DEPTH_C - CNT_W'(n_rx_tail) + CNT_W'(n_rx_head);
        end
        s_rx_cnt_ext    = {sfp_pkg::RXC_W'(0), s_rx_cnt};
        s_pend.rx_count = s_rx_cnt_ext[sfp_pkg::RXC_W-1:0];
        s_pend.tx_busy  = n_sending;
    end

    // Advance pointers only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_sending <= 1'b0;
        end else if (i_accept) begin
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_sending <= n_sending;
        end
    end

    assign o_mem      = i_accept ? s_mem : '0;
    assign o_tx_waddr = r_tx_head;
    assign o_tx_raddr = r_tx_tail;
    assign o_rx_waddr = r_rx_head;
    assign o_rx_raddr = r_rx_tail;
    assign o_pend     = s_pend;

    // A queued transmit byte exists only while the line is busy
    a_queue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_head != r_tx_tail) |-> r_sending)
        else $error("transmit queue holds bytes while idle");

    // Receive pointers stay inside the ring
    a_rx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rx_head} < DEPTH_C) && ({1'b0, r_rx_tail} < DEPTH_C))
        else $error("receive pointer out of range");

    // Never read and write the same ring for one request
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem.tx_we && o_mem.tx_re) && !(o_mem.rx_we && o_mem.rx_re))
        else $error("ring read and write in one request");

endmodule

### rtl/core/buffered_serial_fifo_pair.sv
// Transmit and receive byte rings between a host and a serial line.
// Input channel (i_in_valid / o_in_stall / i_in) carries one request:
// host send, host read, byte received from the line, or line ready.
// Output channel (o_out_valid / i_out_stall / o_out) returns exactly one
// result per request, in request order, with the receive fill level and
// the transmitter busy flag after that request.
// Each ring holds up to DEPTH-1 bytes; a send to a full transmit ring and
// a line byte into a full receive ring are dropped with accepted low.
// A result passes the ring memory read, taken with the pending stage,
// and then the output register. Throughput: one request per cycle while
// o_in_stall is low. Pointers update at accept, so the ring memories are
// read and written at most once per request each.
// Reset clears the ring pointers and the busy flag; ring contents are not
// cleared and need no clearing pass.
// When the receiver stalls, the output register holds; one more request
// may finish its memory read, then o_in_stall rises until the output drains.
module buffered_serial_fifo_pair #(
    parameter int DEPTH = sfp_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sfp_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sfp_pkg::t_out o_out
);

    localparam int PTR_W = $clog2(DEPTH);

    logic s_accept, s_move;

    sfp_pkg::t_mem_ctl s_mem;
    logic [PTR_W-1:0]  s_tx_waddr, s_tx_raddr, s_rx_waddr, s_rx_raddr;
    logic [sfp_pkg::BYTE_W-1:0] s_tx_rdata, s_rx_rdata;

    logic           r_pend_valid;
    sfp_pkg::t_pend r_pend, n_pend;
    logic           r_out_valid;
    sfp_pkg::t_out  r_out, n_out;

    // Handshake: pending stage moves when the output register is free
    assign s_move     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_pend_valid && !s_move;
    assign s_accept   = i_in_valid && !o_in_stall;

    sfp_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_req      (i_in),
        .o_mem      (s_mem),
        .o_tx_waddr (s_tx_waddr),
        .o_tx_raddr (s_tx_raddr),
        .o_rx_waddr (s_rx_waddr),
        .o_rx_raddr (s_rx_raddr),
        .o_pend     (n_pend)
    );

    sfp_ram #(
        .WIDTH(sfp_pkg::BYTE_W),
        .DEPTH(DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (s_mem.tx_we),
        .i_waddr (s_tx_waddr),
        .i_wdata (i_in.byte_in),
        .i_re    (s_mem.tx_re),
        .i_raddr (s_tx_raddr),
        .o_rdata (s_tx_rdata)
    );

    sfp_ram #(
        .WIDTH(sfp_pkg::BYTE_W),
        .DEPTH(DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (s_mem.rx_we),
        .i_waddr (s_rx_waddr),
        .i_wdata (i_in.byte_in),
        .i_re    (s_mem.rx_re),
        .i_raddr (s_rx_raddr),
        .o_rdata (s_rx_rdata)
    );

    // Merge ring read data into the result
    always_comb begin
        n_out.line_valid = r_pend.line_valid;
        n_out.line_byte  = r_pend.take_tx ? s_tx_rdata : r_pend.line_byte;
        n_out.read_byte  = r_pend.take_rx ? s_rx_rdata : '0;
        n_out.accepted   = r_pend.accepted;
        n_out.rx_count   = r_pend.rx_count;
        n_out.tx_busy    = r_pend.tx_busy;
    end

    // Track occupancy of the pending stage and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_pend_valid <= 1'b1;
            end else if (s_move) begin
                r_pend_valid <= 1'b0;
            end
            if (r_pend_valid && s_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_pend <= n_pend;
        end
        if (r_pend_valid && s_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A byte handed to the line always counts as taking effect
    a_line_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.line_valid) |-> o_out.accepted)
        else $error("line byte without accepted");

    // A nonzero read byte only comes from a successful read
    a_read_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.read_byte != '0)) |-> o_out.accepted)
        else $error("read byte without accepted");

endmodule

### bench/sfp_ring_checker.sv
module sfp_ring_checker #(
    parameter int DEPTH = sfp_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  sfp_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  sfp_pkg::t_out i_out,
    output int            o_mismatches,
    output int            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfp_pkg::*;

    // Mirror of both rings and the transmitter flag
    logic [BYTE_W-1:0] tx_ring [DEPTH];
    logic [BYTE_W-1:0] rx_ring [DEPTH];
    int                tx_wr;
    int                tx_rd;
    int                rx_wr;
    int                rx_rd;
    logic              line_busy;

    t_out due_results [$];
    t_out oldest;
    int   mismatch_count = 0;
    int   due_count      = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = due_count;

    function automatic int ring_advance(int p);
        return (p + 1) % DEPTH;
    endfunction

    // Apply one request to the mirrored rings and return its result
    function automatic t_out serve_request(t_in req);
        t_out res;
        res = '0;
        case (req.req_type)
            REQ_SEND: begin
                if (!line_busy) begin
                    res.line_valid = 1'b1;
                    res.line_byte  = req.byte_in;
                    res.accepted   = 1'b1;
                    line_busy      = 1'b1;
                end else if (ring_advance(tx_wr) != tx_rd) begin
                    tx_ring[tx_wr] = req.byte_in;
                    tx_wr          = ring_advance(tx_wr);
                    res.accepted   = 1'b1;
                end
            end
            REQ_READ: begin
                if (rx_wr != rx_rd) begin
                    res.read_byte = rx_ring[rx_rd];
                    rx_rd         = ring_advance(rx_rd);
                    res.accepted  = 1'b1;
                end
            end
            REQ_LINE_RX: begin
                if (ring_advance(rx_wr) != rx_rd) begin
                    rx_ring[rx_wr] = req.byte_in;
                    rx_wr          = ring_advance(rx_wr);
                    res.accepted   = 1'b1;
                end
            end
            REQ_LINE_RDY: begin
                if (line_busy) begin
                    if (tx_wr == tx_rd) begin
                        line_busy = 1'b0;
                    end else begin
                        res.line_valid = 1'b1;
                        res.line_byte  = tx_ring[tx_rd];
                        tx_rd          = ring_advance(tx_rd);
                        res.accepted   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.rx_count = RXC_W'((rx_wr - rx_rd + DEPTH) % DEPTH);
        res.tx_busy  = line_busy;
        return res;
    endfunction

    // Compare one field and report a difference
    task automatic check_field(string name, logic [BYTE_W-1:0] exp_v,
                               logic [BYTE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
        end
    endtask

    // Predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_wr     = 0;
            tx_rd     = 0;
            rx_wr     = 0;
            rx_rd     = 0;
            line_busy = 1'b0;
            due_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                due_results.push_back(serve_request(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none, actual 0x%0h", $time, i_out);
                end else begin
                    oldest = due_results.pop_front();
                    check_field("line_valid", BYTE_W'(oldest.line_valid),
                                BYTE_W'(i_out.line_valid));
                    check_field("line_byte", oldest.line_byte, i_out.line_byte);
                    check_field("read_byte", oldest.read_byte, i_out.read_byte);
                    check_field("accepted", BYTE_W'(oldest.accepted),
                                BYTE_W'(i_out.accepted));
                    check_field("rx_count", BYTE_W'(oldest.rx_count),
                                BYTE_W'(i_out.rx_count));
                    check_field("tx_busy", BYTE_W'(oldest.tx_busy),
                                BYTE_W'(i_out.tx_busy));
                end
            end
        end
        due_count = due_results.size();
    end

endmodule

### bench/tb_buffered_serial_fifo_pair.sv
module tb_buffered_serial_fifo_pair;
    timeunit 1ns;
    timeprecision 1ps;

    import sfp_pkg::*;

    localparam int RANDOM_REQS = 1750;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_LEN    = 150;
    localparam int DRAIN_WAIT  = 10;
    localparam int OPEN_N      = 22;

    typedef enum int {
        MIX_FILL_TX,
        MIX_DRAIN_TX,
        MIX_FILL_RX,
        MIX_DRAIN_RX,
        MIX_EVEN
    } t_mix;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_res;

    int mismatches;
    int outstanding;
    int burst_left = 0;
    int sent = 0;
    int idle_cycles = 0;
    int rcv_cycles = 0;
    int holds_done = 0;
    int hold_at [2] = '{400, 1500};

    // Opening sequence: idle send, queueing, hand-off, clearing busy, empty reads, line receives
    t_req_type open_kind [OPEN_N] = '{
        REQ_SEND, REQ_SEND, REQ_SEND, REQ_LINE_RDY, REQ_LINE_RDY, REQ_LINE_RDY,
        REQ_LINE_RDY, REQ_READ, REQ_LINE_RX, REQ_LINE_RX, REQ_LINE_RX, REQ_READ,
        REQ_READ, REQ_READ, REQ_READ, REQ_SEND, REQ_LINE_RDY, REQ_SEND,
        REQ_SEND, REQ_LINE_RDY, REQ_LINE_RDY, REQ_LINE_RDY
    };
    logic [BYTE_W-1:0] open_byte [OPEN_N] = '{
        8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF, 8'h00,
        8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h81, 8'h00,
        8'hFF, 8'h00, 8'hFF, 8'h7E, 8'h00, 8'h01,
        8'h80, 8'hFF, 8'h00, 8'hFF
    };

    buffered_serial_fifo_pair i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    sfp_ring_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_req),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_res),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Pick a request kind weighted toward the current mix
    function automatic t_req_type pick_kind(t_mix mix);
        int w [4];
        int r;
        case (mix)
            MIX_FILL_TX:  w = '{70, 10, 10, 10};
            MIX_DRAIN_TX: w = '{15, 10, 10, 65};
            MIX_FILL_RX:  w = '{10, 10, 70, 10};
            MIX_DRAIN_RX: w = '{10, 65, 15, 10};
            default:      w = '{25, 25, 25, 25};
        endcase
        r = $urandom_range(0, 99);
        if (r < w[0]) return REQ_SEND;
        if (r < w[0] + w[1]) return REQ_READ;
        if (r < w[0] + w[1] + w[2]) return REQ_LINE_RX;
        return REQ_LINE_RDY;
    endfunction

    // Offer one request, with a random gap between bursts
    task automatic issue(t_in req);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        burst_left--;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Reset and request stimulus
    initial begin
        t_mix mix;
        int   seg_len;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int i = 0; i < OPEN_N; i++) begin
            issue('{req_type: open_kind[i], byte_in: open_byte[i]});
        end
        sent = 0;
        while (sent < RANDOM_REQS) begin
            mix     = t_mix'($urandom_range(0, 4));
            seg_len = $urandom_range(20, 120);
            for (int j = 0; j < seg_len && sent < RANDOM_REQS; j++) begin
                issue('{req_type: pick_kind(mix), byte_in: BYTE_W'($urandom)});
            end
        end
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stall the result side in patterns, with long holds to back up the pipeline and stall requests
    initial begin
        int style;
        int len;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (holds_done < 2 && rcv_cycles >= hold_at[holds_done]) begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) begin
                    @(negedge clk);
                    rcv_cycles++;
                end
                holds_done++;
            end
            style = $urandom_range(0, 2);
            len   = $urandom_range(5, 60);
            repeat (len) begin
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= (rcv_cycles % 4 == 0);
                endcase
                @(negedge clk);
                rcv_cycles++;
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= IDLE_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

endmodule

### files.f
rtl/core/sfp_pkg.sv
rtl/core/sfp_ram.sv
rtl/core/sfp_ctrl.sv
rtl/core/buffered_serial_fifo_pair.sv
bench/sfp_ring_checker.sv
bench/tb_buffered_serial_fifo_pair.sv
